// ===== rtl/integer_partition_generator_assert.svh =====
// Assertion macros for the integer partition generator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef INTEGER_PARTITION_GENERATOR_ASSERT_SVH
`define INTEGER_PARTITION_GENERATOR_ASSERT_SVH

// same-cycle implication
`define IPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipg_pkg.sv =====
// Shared types, constants and microcode table of the integer partition generator.
// No dependencies.
package ipg_pkg;

  localparam int unsigned MAX_TARGET = 32;
  localparam int unsigned TGT_W      = 6;
  localparam int unsigned PART_W     = 6;
  localparam int unsigned SUM_W      = TGT_W + 1;
  localparam int unsigned DEPTH_W    = $clog2(MAX_TARGET + 1);
  localparam int unsigned ADDR_W     = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned PC_W       = 5;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_RDTOP,
    OP_LDTOP,
    OP_PUSH1,
    OP_SETBT,
    OP_POP,
    OP_DEC,
    OP_RDPREV,
    OP_SUBTOP,
    OP_PUSHINC,
    OP_CLRK,
    OP_RDK,
    OP_SENDK,
    OP_POPEMIT,
    OP_ENDFIN,
    OP_SENDDONE
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOREQ,
    C_FIN,
    C_STARTED,
    C_ZERO,
    C_EQ,
    C_GT,
    C_BT,
    C_FULL,
    C_INC,
    C_OUTBUSY,
    C_KMORE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic noreq;
    logic fin;
    logic started;
    logic zero;
    logic eq;
    logic gt;
    logic bt;
    logic full;
    logic inc;
    logic outbusy;
    logic kmore;
  } flags_t;

  localparam logic [PC_W-1:0] S_WAIT    = PC_W'(0);
  localparam logic [PC_W-1:0] S_LOOP    = PC_W'(4);
  localparam logic [PC_W-1:0] S_SETBT   = PC_W'(10);
  localparam logic [PC_W-1:0] S_POP     = PC_W'(11);
  localparam logic [PC_W-1:0] S_BACK    = PC_W'(12);
  localparam logic [PC_W-1:0] S_INC     = PC_W'(16);
  localparam logic [PC_W-1:0] S_EMIT    = PC_W'(17);
  localparam logic [PC_W-1:0] S_RDK     = PC_W'(18);
  localparam logic [PC_W-1:0] S_SENDK   = PC_W'(19);
  localparam logic [PC_W-1:0] S_END     = PC_W'(22);
  localparam logic [PC_W-1:0] S_DONE    = PC_W'(23);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_W'(0):  w = '{op: OP_ACCEPT,   cond: C_NOREQ,   target: S_WAIT};
      PC_W'(1):  w = '{op: OP_NOP,      cond: C_FIN,     target: S_DONE};
      PC_W'(2):  w = '{op: OP_NOP,      cond: C_STARTED, target: S_LOOP};
      PC_W'(3):  w = '{op: OP_INIT,     cond: C_NEVER,   target: S_WAIT};
      PC_W'(4):  w = '{op: OP_RDTOP,    cond: C_ZERO,    target: S_END};
      PC_W'(5):  w = '{op: OP_LDTOP,    cond: C_EQ,      target: S_EMIT};
      PC_W'(6):  w = '{op: OP_NOP,      cond: C_GT,      target: S_POP};
      PC_W'(7):  w = '{op: OP_NOP,      cond: C_BT,      target: S_BACK};
      PC_W'(8):  w = '{op: OP_NOP,      cond: C_FULL,    target: S_SETBT};
      PC_W'(9):  w = '{op: OP_PUSH1,    cond: C_ALWAYS,  target: S_LOOP};
      PC_W'(10): w = '{op: OP_SETBT,    cond: C_ALWAYS,  target: S_LOOP};
      PC_W'(11): w = '{op: OP_POP,      cond: C_ALWAYS,  target: S_LOOP};
      PC_W'(12): w = '{op: OP_DEC,      cond: C_NEVER,   target: S_WAIT};
      PC_W'(13): w = '{op: OP_RDPREV,   cond: C_NEVER,   target: S_WAIT};
      PC_W'(14): w = '{op: OP_NOP,      cond: C_INC,     target: S_INC};
      PC_W'(15): w = '{op: OP_SUBTOP,   cond: C_ALWAYS,  target: S_LOOP};
      PC_W'(16): w = '{op: OP_PUSHINC,  cond: C_ALWAYS,  target: S_LOOP};
      PC_W'(17): w = '{op: OP_CLRK,     cond: C_NEVER,   target: S_WAIT};
      PC_W'(18): w = '{op: OP_RDK,      cond: C_NEVER,   target: S_WAIT};
      PC_W'(19): w = '{op: OP_SENDK,    cond: C_OUTBUSY, target: S_SENDK};
      PC_W'(20): w = '{op: OP_NOP,      cond: C_KMORE,   target: S_RDK};
      PC_W'(21): w = '{op: OP_POPEMIT,  cond: C_ALWAYS,  target: S_WAIT};
      PC_W'(22): w = '{op: OP_ENDFIN,   cond: C_NEVER,   target: S_WAIT};
      PC_W'(23): w = '{op: OP_SENDDONE, cond: C_OUTBUSY, target: S_DONE};
      PC_W'(24): w = '{op: OP_NOP,      cond: C_ALWAYS,  target: S_WAIT};
      default:   w = '{op: OP_NOP,      cond: C_ALWAYS,  target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ipg_useq.sv =====
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on ipg_pkg.
module ipg_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ipg_pkg::flags_t flags_i,
  output ipg_pkg::uword_t ctrl_o
);

  logic [ipg_pkg::PC_W-1:0] pc_q, pc_d;
  ipg_pkg::uword_t          word;
  logic                     take;

  always_comb begin
    word = ipg_pkg::ucode(pc_q);
    unique case (word.cond)
      ipg_pkg::C_NEVER:   take = 1'b0;
      ipg_pkg::C_ALWAYS:  take = 1'b1;
      ipg_pkg::C_NOREQ:   take = flags_i.noreq;
      ipg_pkg::C_FIN:     take = flags_i.fin;
      ipg_pkg::C_STARTED: take = flags_i.started;
      ipg_pkg::C_ZERO:    take = flags_i.zero;
      ipg_pkg::C_EQ:      take = flags_i.eq;
      ipg_pkg::C_GT:      take = flags_i.gt;
      ipg_pkg::C_BT:      take = flags_i.bt;
      ipg_pkg::C_FULL:    take = flags_i.full;
      ipg_pkg::C_INC:     take = flags_i.inc;
      ipg_pkg::C_OUTBUSY: take = flags_i.outbusy;
      ipg_pkg::C_KMORE:   take = flags_i.kmore;
      default:            take = 1'b0;
    endcase
    pc_d   = take ? word.target : pc_q + 1'b1;
    ctrl_o = word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ipg_pkg::S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/ipg_dpath.sv =====
// Datapath: part stack memory, depth, sum and flag registers, result register.
// Depends on ipg_pkg; driven by the control word from ipg_useq.
module ipg_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ipg_pkg::uword_t            ctrl_i,
  output ipg_pkg::flags_t            flags_o,
  input  logic                       cfg_valid_i,
  input  logic [ipg_pkg::TGT_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       restart_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [ipg_pkg::PART_W-1:0] out_part_o,
  output logic                       out_last_o,
  output logic                       out_done_o
);

  logic [ipg_pkg::PART_W-1:0]  stack_mem [ipg_pkg::MAX_TARGET];

  logic [ipg_pkg::DEPTH_W-1:0] depth_q, depth_d, k_q, k_d, dm1;
  logic [ipg_pkg::SUM_W-1:0]   sum_q, sum_d, top_ext, t_ext;
  logic                        bt_q, bt_d, started_q, started_d, finished_q, finished_d;
  logic [ipg_pkg::TGT_W-1:0]   target_q, target_d, t_eff;
  logic [ipg_pkg::PART_W-1:0]  top_q, rd_q;
  logic                        out_valid_q, out_valid_d, out_last_q, out_done_q;
  logic [ipg_pkg::PART_W-1:0]  out_part_q;
  logic                        out_load, out_last_d, out_done_d, outbusy, accept;
  logic [ipg_pkg::PART_W-1:0]  out_part_d;
  logic                        we, re;
  logic [ipg_pkg::ADDR_W-1:0]  wa, ra;
  logic [ipg_pkg::PART_W-1:0]  wd;

  always_comb begin
    if (target_q == '0) begin
      t_eff = ipg_pkg::TGT_W'(1);
    end else if (int'(target_q) > ipg_pkg::MAX_TARGET) begin
      t_eff = ipg_pkg::TGT_W'(ipg_pkg::MAX_TARGET);
    end else begin
      t_eff = target_q;
    end
  end

  assign t_ext      = {1'b0, t_eff};
  assign top_ext    = ipg_pkg::SUM_W'(top_q);
  assign dm1        = depth_q - 1'b1;
  assign in_ready_o = (ctrl_i.op == ipg_pkg::OP_ACCEPT);
  assign accept     = in_valid_i & in_ready_o;
  assign outbusy    = out_valid_q & ~out_ready_i;

  always_comb begin
    flags_o.noreq   = ~in_valid_i;
    flags_o.fin     = finished_q;
    flags_o.started = started_q;
    flags_o.zero    = (depth_q == '0);
    flags_o.eq      = (sum_q == t_ext);
    flags_o.gt      = (sum_q > t_ext);
    flags_o.bt      = bt_q;
    flags_o.full    = (depth_q == ipg_pkg::DEPTH_W'(ipg_pkg::MAX_TARGET));
    flags_o.inc     = (depth_q == '0) ? (top_q < t_eff) : (rd_q > top_q);
    flags_o.outbusy = outbusy;
    flags_o.kmore   = (k_q != depth_q);
  end

  always_comb begin
    we = 1'b0;
    wa = depth_q[ipg_pkg::ADDR_W-1:0];
    wd = ipg_pkg::PART_W'(1);
    re = 1'b0;
    ra = dm1[ipg_pkg::ADDR_W-1:0];
    depth_d    = depth_q;
    sum_d      = sum_q;
    bt_d       = bt_q;
    started_d  = started_q;
    finished_d = finished_q;
    target_d   = target_q;
    k_d        = k_q;
    out_load   = 1'b0;
    out_part_d = out_part_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    unique case (ctrl_i.op)
      ipg_pkg::OP_ACCEPT: begin
        if (accept && restart_i) begin
          started_d  = 1'b0;
          finished_d = 1'b0;
        end
      end
      ipg_pkg::OP_INIT: begin
        we        = 1'b1;
        wa        = '0;
        depth_d   = ipg_pkg::DEPTH_W'(1);
        sum_d     = ipg_pkg::SUM_W'(1);
        bt_d      = 1'b0;
        started_d = 1'b1;
      end
      ipg_pkg::OP_RDTOP, ipg_pkg::OP_RDPREV: begin
        re = 1'b1;
      end
      ipg_pkg::OP_PUSH1: begin
        we      = 1'b1;
        depth_d = depth_q + 1'b1;
        sum_d   = sum_q + 1'b1;
      end
      ipg_pkg::OP_SETBT: begin
        bt_d = 1'b1;
      end
      ipg_pkg::OP_POP: begin
        sum_d   = sum_q - top_ext;
        depth_d = dm1;
        bt_d    = 1'b1;
      end
      ipg_pkg::OP_DEC: begin
        depth_d = dm1;
      end
      ipg_pkg::OP_SUBTOP: begin
        sum_d = sum_q - top_ext;
      end
      ipg_pkg::OP_PUSHINC: begin
        we      = 1'b1;
        wd      = top_q + 1'b1;
        depth_d = depth_q + 1'b1;
        sum_d   = sum_q + 1'b1;
        bt_d    = 1'b0;
      end
      ipg_pkg::OP_CLRK: begin
        k_d = '0;
      end
      ipg_pkg::OP_RDK: begin
        re = 1'b1;
        ra = k_q[ipg_pkg::ADDR_W-1:0];
      end
      ipg_pkg::OP_SENDK: begin
        if (!outbusy) begin
          out_load   = 1'b1;
          out_part_d = rd_q;
          out_last_d = ((k_q + 1'b1) == depth_q);
          out_done_d = 1'b0;
          k_d        = k_q + 1'b1;
        end
      end
      ipg_pkg::OP_POPEMIT: begin
        sum_d   = sum_q - top_ext;
        depth_d = dm1;
        bt_d    = 1'b1;
        if (dm1 == '0) begin
          finished_d = 1'b1;
        end
      end
      ipg_pkg::OP_ENDFIN: begin
        finished_d = 1'b1;
        depth_d    = '0;
        sum_d      = '0;
      end
      ipg_pkg::OP_SENDDONE: begin
        if (!outbusy) begin
          out_load   = 1'b1;
          out_part_d = '0;
          out_last_d = 1'b1;
          out_done_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (cfg_valid_i) begin
      target_d   = cfg_data_i;
      started_d  = 1'b0;
      finished_d = 1'b0;
    end
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= stack_mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == ipg_pkg::OP_LDTOP) begin
      top_q <= rd_q;
    end
    out_part_q <= out_part_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      sum_q       <= '0;
      bt_q        <= 1'b0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      target_q    <= ipg_pkg::TGT_W'(1);
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      sum_q       <= sum_d;
      bt_q        <= bt_d;
      started_q   <= started_d;
      finished_q  <= finished_d;
      target_q    <= target_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_part_o  = out_part_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

// ===== rtl/integer_partition_generator.sv =====
// Top level of the integer partition generator: sequencer plus datapath.
// Depends on ipg_pkg, ipg_useq, ipg_dpath and integer_partition_generator_assert.svh.
//
//   channel   dir  handshake                     payload
//   cfg       in   cfg_valid_i / cfg_ready_o     cfg_data_i = target_value
//   s_axis    in   s_axis_tvalid / s_axis_tready tdata[0] = restart
//   m_axis    out  m_axis_tvalid / m_axis_tready tdata[5:0] = part, tlast, tuser = done
//
// A request steps the microcode loop, pushing or popping the part stack, until a partition
// is found, then sends its parts one at a time; once the enumeration is finished it sends a
// single done result instead, a zero part with tlast and tuser set.
// Reset clears control state; target_value resets to 1. A stalled m_axis holds the
// sequencer on its send step; cfg is always ready and restarts the enumeration.
module integer_partition_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,     // target_value
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] restart, [7:1] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] part, [7:6] zero
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] done_res
);

  ipg_pkg::uword_t            ctrl;
  ipg_pkg::flags_t            flags;
  logic [ipg_pkg::PART_W-1:0] part;
  logic                       cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  ipg_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  ipg_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .cfg_valid_i (cfg_wr),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_part_o  (part),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, part};

`include "integer_partition_generator_assert.svh"

  `IPG_ASSERT_IMP(a_done_shape, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0), "done result must be a zero last part")
  `IPG_ASSERT_IMP(a_push_room, ctrl.op == ipg_pkg::OP_PUSH1 || ctrl.op == ipg_pkg::OP_PUSHINC, !flags.full, "push into a full stack")
  `IPG_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in progress")

endmodule

// ===== dv/integer_partition_generator_tb.sv =====
// Self-checking testbench for integer_partition_generator: streams next and restart requests,
// rewrites the target between phases and checks every emitted part against a local predictor.
// Depends on ipg_pkg and the integer_partition_generator RTL.
module integer_partition_generator_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_GOAL  = 320;

  typedef struct packed {
    logic [5:0] part;
    logic       last;
    logic       done;
  } part_result_t;

  class partition_scoreboard;
    logic [5:0]   parts [ipg_pkg::MAX_TARGET];
    int           depth;
    int           total;
    bit           backtrack;
    bit           active;
    bit           exhausted;
    logic [5:0]   target_reg;
    part_result_t pending[$];
    bit           last_done;
    int           errors;
    int           checked;
    int           requests;
    int           restarts;
    int           done_seen;
    int           writes;

    function new();
      foreach (parts[i]) parts[i] = '0;
      depth      = 0;
      total      = 0;
      backtrack  = 1'b0;
      active     = 1'b0;
      exhausted  = 1'b0;
      target_reg = 6'd1;
      errors     = 0;
      checked    = 0;
      requests   = 0;
      restarts   = 0;
      done_seen  = 0;
      writes     = 0;
    endfunction

    function void set_target(logic [5:0] value);
      target_reg = value;
      active     = 1'b0;
      exhausted  = 1'b0;
      writes++;
    endfunction

    function int effective_target();
      int t;
      t = target_reg;
      if (t < 1) t = 1;
      if (t > ipg_pkg::MAX_TARGET) t = ipg_pkg::MAX_TARGET;
      return t;
    endfunction

    function void push_done();
      part_result_t r;
      r.part = '0;
      r.last = 1'b1;
      r.done = 1'b1;
      pending = {pending, r};
      last_done = 1'b1;
    endfunction

    // Advance the enumeration to the next partition and queue its parts, or queue a done result once it is exhausted.
    function void note_request(bit restart);
      int t;
      int top;
      part_result_t r;
      t = effective_target();
      last_done = 1'b0;
      requests++;
      if (restart) begin
        restarts++;
        active    = 1'b0;
        exhausted = 1'b0;
      end
      if (exhausted) begin
        push_done();
        return;
      end
      if (!active) begin
        parts[0]  = 6'd1;
        depth     = 1;
        total     = 1;
        backtrack = 1'b0;
        active    = 1'b1;
      end
      while (depth > 0 && depth <= ipg_pkg::MAX_TARGET) begin
        top = parts[depth-1];
        if (total == t) begin
          for (int k = 0; k < depth; k++) begin
            r.part = parts[k];
            r.last = (k + 1 == depth);
            r.done = 1'b0;
            pending = {pending, r};
          end
          total -= top;
          depth--;
          backtrack = 1'b1;
          if (depth == 0) exhausted = 1'b1;
          return;
        end else if (total > t) begin
          total -= top;
          depth--;
          backtrack = 1'b1;
        end else if (!backtrack) begin
          if (depth < ipg_pkg::MAX_TARGET) begin
            parts[depth] = 6'd1;
            depth++;
            total++;
          end else begin
            backtrack = 1'b1;
          end
        end else begin
          depth--;
          if ((depth > 0 && parts[depth-1] > top) || (depth == 0 && top < t)) begin
            parts[depth] = 6'(top + 1);
            depth++;
            total++;
            backtrack = 1'b0;
          end else begin
            total -= top;
          end
        end
      end
      exhausted = 1'b1;
      depth     = 0;
      total     = 0;
      push_done();
    endfunction

    function void check_result(logic [5:0] part, logic last, logic done);
      part_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual part %0d last %0b done %0b",
                 $time, part, last, done);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (done) done_seen++;
      if (part !== exp.part) begin
        errors++;
        $display("%0t: part mismatch, expected %0d, actual %0d", $time, exp.part, part);
      end
      if (last !== exp.last) begin
        errors++;
        $display("%0t: last_part mismatch, expected %0b, actual %0b", $time, exp.last, last);
      end
      if (done !== exp.done) begin
        errors++;
        $display("%0t: done_res mismatch, expected %0b, actual %0b", $time, exp.done, done);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [0] restart, [7:1] zero
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [5:0] part, [7:6] zero
  logic       m_axis_tlast;
  logic       m_axis_tuser;   // [0] done_res

  partition_scoreboard sb;
  bit steady_flow;
  int rx_hold_cycles;
  int items_sent;
  int idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  integer_partition_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // End the run when no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.pending.size());
        $display("integer_partition_generator test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[5:0], m_axis_tlast, m_axis_tuser);
      @(negedge clk_i);
    end
  end

  task automatic send_item(bit restart);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(restart);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_target(logic [5:0] value);
    wait_for_results();
    repeat (8) @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_target(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int phase;
    int pick;
    int cap;
    int n_phase;
    int past_end;
    logic [5:0] tgt;
    sb             = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    steady_flow    = 1'b0;
    rx_hold_cycles = 0;
    items_sent     = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // target after reset, past the end and restart
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    program_target(6'd3);
    repeat (5) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // rewrite mid-enumeration
    program_target(6'd5);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);

    program_target(6'd0);
    send_item(1'b0);
    send_item(1'b0);

    program_target(6'd63);
    send_item(1'b0);
    send_item(1'b0);

    program_target(6'd32);
    send_item(1'b1);
    send_item(1'b0);

    program_target(6'd2);
    repeat (3) send_item(1'b0);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      phase++;
      pick = $urandom_range(0, 9);
      if (pick < 6) tgt = 6'($urandom_range(1, 8));
      else if (pick < 9) tgt = 6'($urandom_range(9, 20));
      else tgt = 6'($urandom_range(21, 63));
      if (phase == 3) tgt = 6'd7;
      program_target(tgt);
      steady_flow = (phase % 4 == 0) || (phase == 3);
      if (phase == 3) rx_hold_cycles = 300;
      cap      = (sb.effective_target() <= 8) ? 40 : 6;
      n_phase  = 0;
      past_end = 0;
      while (n_phase < cap && past_end < 2) begin
        send_item($urandom_range(0, 15) == 0);
        if (sb.last_done) past_end++;
        n_phase++;
        if (phase == 2 && n_phase == 5) wait_for_results();
      end
    end
    steady_flow = 1'b0;

    wait_for_results();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d requests (%0d restarts) over %0d target writes", sb.requests,
             sb.restarts, sb.writes);
    $display("Checked %0d results, %0d of them end-of-enumeration", sb.checked, sb.done_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("integer_partition_generator test passed");
    end else begin
      $display("integer_partition_generator test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ipg_pkg.sv
rtl/ipg_useq.sv
rtl/ipg_dpath.sv
rtl/integer_partition_generator.sv
dv/integer_partition_generator_tb.sv
